// File: rtl/fird_pkg.sv
package fird_pkg;

   localparam int TAP_COUNT = 17;
   localparam int HALF_TAPS = 9;
   localparam int SAMPLE_W = 32;
   // Wide enough for the largest coefficient at 30 fractional bits.
   localparam int COEF_W = 28;
   localparam int PROD_W = SAMPLE_W + COEF_W;
   // A shifted product stays well below 2^28 in magnitude.
   localparam int TERM_W = 34;
   localparam int ACC_W = 36;

   // Node counts of the registered adder tree, level by level.
   localparam int L1_N = (TAP_COUNT + 1) / 2;
   localparam int L2_N = (L1_N + 1) / 2;
   localparam int L3_N = (L2_N + 1) / 2;
   localparam int L4_N = (L3_N + 1) / 2;

   // Half of the symmetric coefficient set, in units of 1e-7.
   localparam longint COEF_E7 [HALF_TAPS] = '{
      74662, 109120, 206629, 354434, 530993,
      709415, 861884, 964305, 1000366
   };

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef sample_type sample_arr_type [TAP_COUNT];
   typedef term_type term_arr_type [TAP_COUNT];

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   // Coefficient of one tap in Q format, rounded half up.
   function automatic coef_type coef_q(input int tap, input int frac_bits);
      int k;
      longint scaled;
      k = (tap < HALF_TAPS) ? tap : (TAP_COUNT - 1 - tap);
      scaled = (COEF_E7[k] << frac_bits) + 64'sd5000000;
      return coef_type'(scaled / 64'sd10000000);
   endfunction

endpackage

// File: rtl/fir_decimator_17tap.sv
// 17-tap symmetric low-pass FIR filter with decimation.
//
// Input channel (req_): one signed sample per item, FRAC_BITS fractional
// bits. Every accepted item is shifted into the 17-entry delay line. After
// every DECIMATION-th item the filter sum over the delay line is computed.
// Result channel (rsp_): one saturated sample per DECIMATION input items.
//
// Throughput is one input item per cycle while no result waits on rsp_ready.
// The products of all 17 taps are formed in parallel, one multiplier per
// tap, and summed by a registered adder tree. The delay line loads at the
// edge that accepts the item that completed its phase; the result then
// passes the product register, the adder-tree levels and the saturating
// output register before it appears on rsp_valid.
//
// While a result waits on rsp_ready, the whole pipeline holds and req_ready
// is low; when the output register is empty or being read, items flow on.
// Synchronous reset clears the delay line to zero, restarts the phase count
// and drops every item still in flight.
module fir_decimator_17tap
   import fird_pkg::*;
#(
   parameter int DECIMATION = 10,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_filtered_out
);

   sample_arr_type taps;
   term_arr_type   terms;
   logic           fire;
   logic           terms_valid;
   logic           advance;
   pipe_ctl_type   tap_ctl;
   pipe_ctl_type   mult_ctl;

   assign req_ready = advance;
   assign tap_ctl = '{advance: advance, valid: req_valid};
   assign mult_ctl = '{advance: advance, valid: fire};

   fird_taps #(
      .DECIMATION(DECIMATION)
   ) u_taps (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tap_ctl),
      .sample_in(req_sample_in),
      .taps     (taps),
      .fire     (fire)
   );

   fird_mult #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mult_ctl),
      .taps       (taps),
      .terms      (terms),
      .terms_valid(terms_valid)
   );

   fird_sum u_sum (
      .clock           (clock),
      .reset           (reset),
      .terms           (terms),
      .terms_valid     (terms_valid),
      .rsp_ready       (rsp_ready),
      .advance         (advance),
      .rsp_valid       (rsp_valid),
      .rsp_filtered_out(rsp_filtered_out)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while a result is stalled");

   a_free_output_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with an empty output register");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_filtered_out))
      else $error("stalled result changed");

endmodule

// File: rtl/fird_taps.sv
module fird_taps
   import fird_pkg::*;
#(
   parameter int DECIMATION = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  pipe_ctl_type   ctl,
   input  sample_type     sample_in,
   output sample_arr_type taps,
   output logic           fire
);

   localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

   sample_type         delay_ff [TAP_COUNT];
   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic               fire_ff;
   logic               fire_in;
   logic               accept;
   logic               last;

   assign accept = ctl.valid && ctl.advance;
   assign last = (({1'b0, phase_ff} + (PHASE_W + 1)'(1)) == (PHASE_W + 1)'(DECIMATION));

   always_comb begin
      phase_in = phase_ff;
      fire_in = fire_ff;
      if (ctl.advance) begin
         fire_in = accept && last;
      end
      if (accept) begin
         phase_in = last ? '0 : phase_ff + PHASE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            delay_ff[i] <= '0;
         end
         phase_ff <= '0;
         fire_ff <= 1'b0;
      end else begin
         if (accept) begin
            delay_ff[0] <= sample_in;
            for (int i = 1; i < TAP_COUNT; i++) begin
               delay_ff[i] <= delay_ff[i-1];
            end
         end
         phase_ff <= phase_in;
         fire_ff <= fire_in;
      end
   end

   assign taps = delay_ff;
   assign fire = fire_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_W'(DECIMATION - 1))
      else $error("phase counter beyond decimation factor");

   a_fire_on_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> fire_ff)
      else $error("last sample of a phase did not start a result");

   a_no_fire_early: assert property (@(posedge clock) disable iff (reset)
      (accept && !last) |=> !fire_ff)
      else $error("result started before phase end");

endmodule

// File: rtl/fird_mult.sv
module fird_mult
   import fird_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  pipe_ctl_type   ctl,
   input  sample_arr_type taps,
   output term_arr_type   terms,
   output logic           terms_valid
);

   term_type term_in [TAP_COUNT];
   term_type term_ff [TAP_COUNT];
   logic     valid_ff;

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      localparam coef_type COEF_K = coef_q(k, FRAC_BITS);
      prod_type prod;
      // The arithmetic shift floors each product before it is summed.
      assign prod = taps[k] * COEF_K;
      assign term_in[k] = term_type'(prod >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int i = 0; i < TAP_COUNT; i++) begin
            term_ff[i] <= term_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   assign terms = term_ff;
   assign terms_valid = valid_ff;

endmodule

// File: rtl/fird_sum.sv
module fird_sum
   import fird_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  term_arr_type terms,
   input  logic         terms_valid,
   input  logic         rsp_ready,
   output logic         advance,
   output logic         rsp_valid,
   output sample_type   rsp_filtered_out
);

   localparam acc_type SAT_MAX = acc_type'(32'sh7FFF_FFFF);
   localparam acc_type SAT_MIN = acc_type'(32'sh8000_0000);

   acc_type    l1_in [L1_N];
   acc_type    l1_ff [L1_N];
   acc_type    l2_in [L2_N];
   acc_type    l2_ff [L2_N];
   acc_type    l3_in [L3_N];
   acc_type    l3_ff [L3_N];
   acc_type    l4_in [L4_N];
   acc_type    l4_ff [L4_N];
   acc_type    total;
   sample_type out_in;
   sample_type out_ff;
   logic [3:0] valid_ff;
   logic       out_valid_ff;

   // The whole pipeline moves unless a finished result is still waiting.
   assign advance = !out_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < L1_N; i++) begin
         if (2 * i + 1 < TAP_COUNT) begin
            l1_in[i] = acc_type'(terms[2*i]) + acc_type'(terms[2*i+1]);
         end else begin
            l1_in[i] = acc_type'(terms[2*i]);
         end
      end
      for (int i = 0; i < L2_N; i++) begin
         l2_in[i] = (2 * i + 1 < L1_N) ? l1_ff[2*i] + l1_ff[2*i+1] : l1_ff[2*i];
      end
      for (int i = 0; i < L3_N; i++) begin
         l3_in[i] = (2 * i + 1 < L2_N) ? l2_ff[2*i] + l2_ff[2*i+1] : l2_ff[2*i];
      end
      for (int i = 0; i < L4_N; i++) begin
         l4_in[i] = (2 * i + 1 < L3_N) ? l3_ff[2*i] + l3_ff[2*i+1] : l3_ff[2*i];
      end
      total = l4_ff[0] + l4_ff[1];
      if (total > SAT_MAX) begin
         out_in = sample_type'(SAT_MAX);
      end else if (total < SAT_MIN) begin
         out_in = sample_type'(SAT_MIN);
      end else begin
         out_in = total[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         l1_ff <= l1_in;
         l2_ff <= l2_in;
         l3_ff <= l3_in;
         l4_ff <= l4_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], terms_valid};
         out_valid_ff <= valid_ff[3];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_filtered_out = out_ff;

endmodule

// File: dv/fird_checker.sv
module fird_response_checker
   import fird_pkg::*;
#(
   parameter int DECIMATION = 10,
   parameter int FRAC_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  sample_type req_sample_in,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  sample_type rsp_filtered_out,
   output int         mismatch_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Half of the symmetric tap weights, in units of 1e-7.
   localparam longint WEIGHT_E7 [HALF_TAPS] = '{
      74662, 109120, 206629, 354434, 530993,
      709415, 861884, 964305, 1000366
   };

   sample_type     history [TAP_COUNT];
   logic [5:0]     samples_since_out;
   sample_type     filtered_q [$];
   int             errors;

   // Q-format weight of one tap, rounded half up.
   function automatic longint tap_weight(input int tap);
      int mirror;
      mirror = (tap < HALF_TAPS) ? tap : (TAP_COUNT - 1 - tap);
      return ((WEIGHT_E7[mirror] <<< FRAC_BITS) + 64'sd5000000) / 64'sd10000000;
   endfunction

   // Sum of the truncated products over the window, clamped to 32 bits.
   function automatic sample_type window_sum(input sample_type taps [TAP_COUNT]);
      longint acc;
      longint term;
      acc = 0;
      for (int t = 0; t < TAP_COUNT; t++) begin
         term = (tap_weight(t) * longint'(taps[t])) >>> FRAC_BITS;
         acc += term;
      end
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return sample_type'(acc);
   endfunction

   always @(posedge clock) begin
      logic [5:0] next_count;
      sample_type want;
      if (reset) begin
         for (int t = 0; t < TAP_COUNT; t++) history[t] = '0;
         samples_since_out = '0;
         filtered_q.delete();
         errors = 0;
      end else begin
         // Compare first: an item accepted at this edge cannot already be on rsp_.
         if (rsp_valid && rsp_ready) begin
            if (filtered_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: unexpected result, filtered_out = %0d",
                           $realtime, rsp_filtered_out);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_filtered_out !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: filtered_out mismatch, expected %0d, got %0d",
                              $realtime, want, rsp_filtered_out);
               end
            end
         end
         if (req_valid && req_ready) begin
            for (int t = TAP_COUNT - 1; t > 0; t--) history[t] = history[t-1];
            history[0] = req_sample_in;
            next_count = samples_since_out + 6'd1;
            if (next_count == 6'd0 || next_count >= DECIMATION) begin
               samples_since_out = '0;
               filtered_q.push_back(window_sum(history));
            end else begin
               samples_since_out = next_count;
            end
         end
      end
      mismatch_count <= errors;
      outstanding <= filtered_q.size();
   end

endmodule

// File: dv/tb_fir_decimator_17tap.sv
module tb_fir_decimator_17tap;
   timeunit 1ns;
   timeprecision 1ps;
   import fird_pkg::*;

   localparam int DECIMATION = 10;
   localparam int FRAC_BITS = 16;
   localparam int RANDOM_ITEMS = 550;
   // The completing item's result still passes the product, adder-tree and output registers.
   localparam int DRAIN_CYCLES = 16;
   // Far above the slowest legal run of about 600 items with heavy stalls.
   localparam int CYCLE_LIMIT = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   sample_type req_sample_in = '0;
   logic       rsp_ready = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   sample_type rsp_filtered_out;

   int          mismatch_count;
   int          outstanding;
   int          send_idle_pct = 21;
   int          recv_idle_pct = 49;
   int unsigned cycle_count = 0;

   fir_decimator_17tap #(
      .DECIMATION(DECIMATION),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered_out(rsp_filtered_out)
   );

   // The checker sits beside the block, watches both channels and keeps the
   // running mismatch count and the number of filter outputs still owed.
   fird_response_checker #(
      .DECIMATION(DECIMATION),
      .FRAC_BITS (FRAC_BITS)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered_out(rsp_filtered_out),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides afresh every cycle whether it takes a result. The
   // idle rate follows the current phase of the run.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // A hung handshake or a result that never comes ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** fir_decimator_17tap: FAILED **");
         $finish;
      end
   end

   // Offers one item, after a random number of idle cycles, and holds it
   // until the block takes it. The valid line gets a single assignment per
   // edge, so back-to-back items keep it high without a glitch.
   task automatic send_sample(input sample_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random samples: full range most often, with small values to exercise the
   // floor of negative products, the extremes, and assorted magnitudes.
   function automatic sample_type pick_sample();
      int unsigned mode;
      mode = $urandom_range(99);
      if (mode < 45) begin
         return sample_type'($urandom);
      end else if (mode < 70) begin
         return sample_type'(int'($urandom_range(2097152)) - 1048576);
      end else if (mode < 85) begin
         case ($urandom_range(4))
            0: return sample_type'(32'h7FFF_FFFF);
            1: return sample_type'(32'h8000_0000);
            2: return sample_type'(0);
            3: return sample_type'(-1);
            default: return sample_type'(1);
         endcase
      end else begin
         return sample_type'($signed($urandom) >>> $urandom_range(31));
      end
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The first output sees the cleared delay line behind
      // ten full-scale positive samples; the second window mixes the largest
      // positive and negative values, and the unit values and zero follow.
      for (int n = 0; n < 12; n++) send_sample(sample_type'(32'h7FFF_FFFF));
      for (int n = 0; n < 10; n++) send_sample(sample_type'(32'h8000_0000));
      send_sample(sample_type'(1));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(0));

      // Random part in three stretches: sender light and receiver heavy,
      // then the reverse, then both sides at full speed.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 21;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_sample(pick_sample());
      end
      req_valid <= 1'b0;

      // Wait for every owed output, then give the pipeline time to show any
      // stray result before the verdict.
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** fir_decimator_17tap: PASSED **");
      end else begin
         $display("** fir_decimator_17tap: FAILED **");
      end
      $finish;
   end

endmodule

// File: fir_decimator_17tap.f
rtl/fird_pkg.sv
rtl/fird_taps.sv
rtl/fird_mult.sv
rtl/fird_sum.sv
rtl/fir_decimator_17tap.sv
dv/fird_checker.sv
dv/tb_fir_decimator_17tap.sv
